FILE: rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  // IoU threshold register: width and reset value (0.3 of 65536)
  localparam int unsigned THR_W     = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd19661;

  // Overlap is scaled by 2^IOU_SHIFT before the compare
  localparam int unsigned IOU_SHIFT = 16;

  // Echoed identifier widths and raw coordinate port width
  localparam int unsigned ID_W   = 8;
  localparam int unsigned PORT_W = 16;

  // Verdict a cell reports when the probe box leaves it
  typedef struct packed {
    logic fin;   // probe stops here (failed, or last kept cell)
    logic pass;  // IoU at or below threshold for this cell
  } gbs_verdict_t;

  // Summary of the whole chain seen by the controller
  typedef struct packed {
    logic done;  // some cell finished the walk this cycle
    logic hit;   // finishing cell passed, so the box survives
  } gbs_walk_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } gbs_state_t;

endpackage

FILE: rtl/gbs_cell.sv
// ----------------------------------------------------------------------------
// gbs_cell
// One slot of the kept list. Holds a kept box and its area, checks a passing
// probe box against it in two register stages and hands it to the next cell.
// ----------------------------------------------------------------------------
module gbs_cell import gbs_pkg::*; #(
  parameter int CW    = 16,
  parameter int CNT_W = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [THR_W-1:0]    thr,
  input  logic                in_vld,
  input  logic [4*CW-1:0]     in_box,
  input  logic [2*CW-1:0]     in_area,
  input  logic [CNT_W-1:0]    in_rem,
  input  logic                wr_en,
  input  logic [4*CW-1:0]     wr_box,
  input  logic [2*CW-1:0]     wr_area,
  output logic                out_vld,
  output logic [4*CW-1:0]     out_box,
  output logic [2*CW-1:0]     out_area,
  output logic [CNT_W-1:0]    out_rem,
  output gbs_verdict_t        verdict
);

  localparam int AW = 2 * CW;
  localparam int SW = AW + 1;
  localparam int RW = SW + THR_W;

  // stored kept box
  logic [4*CW-1:0] s_box;
  logic [AW-1:0]   s_area;

  // stage 1 registers
  logic             p_vld;
  logic [4*CW-1:0]  p_box;
  logic [AW-1:0]    p_area;
  logic [CNT_W-1:0] p_rem;
  logic [AW-1:0]    p_ov;
  logic [SW-1:0]    p_sum;

  logic [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic [CW-1:0] lo_x, hi_x, lo_y, hi_y, iw, ih;
  logic [AW-1:0] ov;
  logic [SW-1:0] uni;
  logic [RW-1:0] lhs, rhs;
  logic          ok;
  logic [CNT_W-1:0] rem_n;

  // slot write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      s_box  <= wr_box;
      s_area <= wr_area;
    end
  end

  // intersection width and height
  always_comb begin
    ax0 = in_box[CW-1:0];
    ay0 = in_box[2*CW-1:CW];
    ax1 = in_box[3*CW-1:2*CW];
    ay1 = in_box[4*CW-1:3*CW];
    bx0 = s_box[CW-1:0];
    by0 = s_box[2*CW-1:CW];
    bx1 = s_box[3*CW-1:2*CW];
    by1 = s_box[4*CW-1:3*CW];
    lo_x = (ax0 > bx0) ? ax0 : bx0;
    hi_x = (ax1 < bx1) ? ax1 : bx1;
    lo_y = (ay0 > by0) ? ay0 : by0;
    hi_y = (ay1 < by1) ? ay1 : by1;
    iw = (hi_x > lo_x) ? hi_x - lo_x : '0;
    ih = (hi_y > lo_y) ? hi_y - lo_y : '0;
    ov = AW'(iw) * AW'(ih);
  end

  // stage 1: overlap area and area sum
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= in_vld;
    end
    p_box  <= in_box;
    p_area <= in_area;
    p_rem  <= in_rem;
    p_ov   <= ov;
    p_sum  <= SW'(in_area) + SW'(s_area);
  end

  // overlap * 2^16 <= threshold * union
  always_comb begin
    uni   = p_sum - SW'(p_ov);
    lhs   = RW'({p_ov, {IOU_SHIFT{1'b0}}});
    rhs   = RW'(uni) * RW'(thr);
    ok    = (lhs <= rhs);
    rem_n = p_rem - CNT_W'(1);
  end

  // stage 2: verdict, forward probe while it passes and slots remain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld     <= 1'b0;
      verdict.fin <= 1'b0;
    end else begin
      out_vld     <= p_vld && ok && (rem_n != '0);
      verdict.fin <= p_vld && (!ok || (rem_n == '0));
    end
    verdict.pass <= ok;
    out_box      <= p_box;
    out_area     <= p_area;
    out_rem      <= rem_n;
  end

endmodule

FILE: rtl/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: takes a box, computes its area, launches it down the non-empty
// cell chain, waits for the verdict, updates the kept list, drives the result.
// ----------------------------------------------------------------------------
module gbs_ctrl import gbs_pkg::*; #(
  parameter int CW       = 16,
  parameter int CNT_W    = 9,
  parameter int MAX_KEPT = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  output logic [THR_W-1:0]   thr,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PORT_W-1:0]  x_min,
  input  logic [PORT_W-1:0]  y_min,
  input  logic [PORT_W-1:0]  x_max,
  input  logic [PORT_W-1:0]  y_max,
  input  logic [ID_W-1:0]    box_index,
  input  logic [ID_W-1:0]    class_id,
  input  logic               last_in_run,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               keep,
  output logic [ID_W-1:0]    out_box_index,
  output logic [ID_W-1:0]    out_class_id,
  output logic               store_overflow,
  output logic               run_done,
  // chain side
  output logic               tok_vld,
  output logic [4*CW-1:0]    tok_box,
  output logic [2*CW-1:0]    tok_area,
  output logic [CNT_W-1:0]   tok_rem,
  output logic               wr_en,
  output logic [CNT_W-1:0]   wr_idx,
  input  gbs_walk_t          walk
);

  localparam int AW = 2 * CW;

  gbs_state_t state;

  logic [CW-1:0]    x0, y0, x1, y1;
  logic [ID_W-1:0]  idx_q, cls_q;
  logic             last_q;
  logic             keep_q;
  logic [CNT_W-1:0] count;
  logic             full;
  logic             load;
  logic [CW-1:0]    ix0, iy0, ix1, iy1;

  assign in_ready = (state == S_IDLE);
  assign full     = (count == CNT_W'(MAX_KEPT));
  assign load     = (state == S_FIN) && (!out_valid || out_ready);
  assign wr_en    = load && keep_q && !full;
  assign wr_idx   = count;
  assign tok_box  = {y1, x1, y0, x0};
  assign tok_rem  = count;

  // coordinates in their low COORD_BITS bits
  always_comb begin
    ix0 = CW'(x_min);
    iy0 = CW'(y_min);
    ix1 = CW'(x_max);
    iy1 = CW'(y_max);
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tok_vld <= 1'b0;
      count   <= '0;
    end else begin
      tok_vld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (count == '0) begin
            state <= S_FIN;
          end else begin
            tok_vld <= 1'b1;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (load) begin
            state <= S_IDLE;
            if (last_q) begin
              count <= '0;
            end else if (wr_en) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture, edge clamp, area and verdict
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x0     <= ix0;
      y0     <= iy0;
      x1     <= (ix1 < ix0) ? ix0 : ix1;
      y1     <= (iy1 < iy0) ? iy0 : iy1;
      idx_q  <= box_index;
      cls_q  <= class_id;
      last_q <= last_in_run;
    end
    if (state == S_PREP) begin
      tok_area <= AW'(x1 - x0) * AW'(y1 - y0);
      keep_q   <= 1'b1;
    end else if (state == S_WALK && walk.done) begin
      keep_q   <= walk.hit;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      keep           <= keep_q;
      out_box_index  <= idx_q;
      out_class_id   <= cls_q;
      store_overflow <= keep_q && full;
      run_done       <= last_q;
    end
  end

endmodule

FILE: rtl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression over one class run with a chain of kept-box cells.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | box edges, index, class, last
//   out     | output    | out_valid / out_ready| keep, index, class, ovf, done
//   cfg     | input     | cfg_wr_en            | iou_threshold
//
// One box is in flight at a time. A box walks the kept cells until one
// suppresses it or the last kept cell passes it; with the list empty it
// skips the chain. The probe spends two register stages in each kept cell.
// The next box is taken once the previous result word has been loaded.
// Reset (rst, synchronous) empties the kept list and sets the threshold.
// A new box is taken while the previous result word waits on out_ready;
// a finished box then holds in the controller until the word is taken.
// ----------------------------------------------------------------------------
module greedy_box_suppression import gbs_pkg::*; #(
  parameter int MAX_KEPT   = 256,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [THR_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PORT_W-1:0]  x_min,
  input  logic [PORT_W-1:0]  y_min,
  input  logic [PORT_W-1:0]  x_max,
  input  logic [PORT_W-1:0]  y_max,
  input  logic [ID_W-1:0]    box_index,
  input  logic [ID_W-1:0]    class_id,
  input  logic               last_in_run,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               keep,
  output logic [ID_W-1:0]    out_box_index,
  output logic [ID_W-1:0]    out_class_id,
  output logic               store_overflow,
  output logic               run_done
);

  localparam int CW    = COORD_BITS;
  localparam int AW    = 2 * CW;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);

  logic [THR_W-1:0] thr;
  logic             l_vld;
  logic [4*CW-1:0]  l_box;
  logic [AW-1:0]    l_area;
  logic [CNT_W-1:0] l_rem;
  logic             wr_en;
  logic [CNT_W-1:0] wr_idx;
  gbs_walk_t        walk;

  // chain links: element k is the output of cell k
  logic [MAX_KEPT-1:0] c_vld;
  logic [4*CW-1:0]     c_box  [MAX_KEPT];
  logic [AW-1:0]       c_area [MAX_KEPT];
  logic [CNT_W-1:0]    c_rem  [MAX_KEPT];
  gbs_verdict_t        c_verd [MAX_KEPT];

  gbs_ctrl #(
    .CW       (CW),
    .CNT_W    (CNT_W),
    .MAX_KEPT (MAX_KEPT)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .thr            (thr),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_min          (x_min),
    .y_min          (y_min),
    .x_max          (x_max),
    .y_max          (y_max),
    .box_index      (box_index),
    .class_id       (class_id),
    .last_in_run    (last_in_run),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keep           (keep),
    .out_box_index  (out_box_index),
    .out_class_id   (out_class_id),
    .store_overflow (store_overflow),
    .run_done       (run_done),
    .tok_vld        (l_vld),
    .tok_box        (l_box),
    .tok_area       (l_area),
    .tok_rem        (l_rem),
    .wr_en          (wr_en),
    .wr_idx         (wr_idx),
    .walk           (walk)
  );

  // row of kept-box cells
  for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
    logic             i_vld;
    logic [4*CW-1:0]  i_box;
    logic [AW-1:0]    i_area;
    logic [CNT_W-1:0] i_rem;

    if (k == 0) begin : g_head
      assign i_vld  = l_vld;
      assign i_box  = l_box;
      assign i_area = l_area;
      assign i_rem  = l_rem;
    end else begin : g_link
      assign i_vld  = c_vld[k-1];
      assign i_box  = c_box[k-1];
      assign i_area = c_area[k-1];
      assign i_rem  = c_rem[k-1];
    end

    gbs_cell #(
      .CW    (CW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .thr      (thr),
      .in_vld   (i_vld),
      .in_box   (i_box),
      .in_area  (i_area),
      .in_rem   (i_rem),
      .wr_en    (wr_en && (wr_idx == CNT_W'(k))),
      .wr_box   (l_box),
      .wr_area  (l_area),
      .out_vld  (c_vld[k]),
      .out_box  (c_box[k]),
      .out_area (c_area[k]),
      .out_rem  (c_rem[k]),
      .verdict  (c_verd[k])
    );
  end

  // only one probe is in the chain, so at most one cell finishes
  always_comb begin
    walk.done = 1'b0;
    walk.hit  = 1'b0;
    for (int k = 0; k < MAX_KEPT; k++) begin
      walk.done = walk.done | c_verd[k].fin;
      walk.hit  = walk.hit | (c_verd[k].fin & c_verd[k].pass);
    end
  end

endmodule

FILE: rtl/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for greedy_box_suppression, attached by bind.
// ----------------------------------------------------------------------------
module gbs_checker import gbs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               keep,
  input logic [ID_W-1:0]    out_box_index,
  input logic [ID_W-1:0]    out_class_id,
  input logic               store_overflow,
  input logic               run_done
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(keep) &&
      $stable(out_box_index) && $stable(out_class_id) &&
      $stable(store_overflow) && $stable(run_done))
    else $error("result word changed while stalled");

  // overflow only reported for a surviving box
  a_ovf_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!store_overflow || keep))
    else $error("overflow flagged on a suppressed box");

  // one box at a time: input closes right after a box is taken
  a_one_box: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second box taken while one is in flight");

  // after reset the block is empty and open for input
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (.*);

FILE: bench/nms_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nms_tb_pkg
// Box types and the result scoreboard for the greedy box suppression bench.
// The scoreboard carries its own kept-box list and IoU threshold, judges
// every accepted box, and checks each result word against the oldest verdict.
// ----------------------------------------------------------------------------
package nms_tb_pkg;
  import gbs_pkg::*;

  // kept-list depth the bench builds the block with
  localparam int KEPT_DEPTH = 256;

  typedef struct {
    bit [PORT_W-1:0] x0, y0, x1, y1;
  } rect_t;

  // one candidate box as offered on the input channel
  typedef struct {
    rect_t        box;
    bit [ID_W-1:0] idx, cls;
    bit           last;
  } cand_t;

  // one result word
  typedef struct {
    bit           keep;
    bit [ID_W-1:0] idx, cls;
    bit           ovf, done;
  } verdict_t;

  class nms_scoreboard;
    bit [THR_W-1:0] thr;
    rect_t          kept_list[KEPT_DEPTH];
    int unsigned    kept_n;
    verdict_t       verdict_q[$];
    int unsigned    errors, words, n_keep, n_drop, n_ovf, n_runs;

    function new();
      thr    = THR_RESET;
      kept_n = 0;
    endfunction

    // length of the common part of two spans, zero if disjoint
    function longint unsigned span_common(bit [PORT_W-1:0] a0, a1, b0, b1);
      bit [PORT_W-1:0] lo, hi;
      longint unsigned r;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      r  = 0;
      if (hi > lo) r = hi - lo;
      return r;
    endfunction

    // exact IoU <= thr / 2^16 test, no division
    function bit iou_ok(rect_t a, rect_t b);
      longint unsigned ov, wa, ha, wb, hb, uni;
      ov  = span_common(a.x0, a.x1, b.x0, b.x1) * span_common(a.y0, a.y1, b.y0, b.y1);
      wa  = a.x1 - a.x0;
      ha  = a.y1 - a.y0;
      wb  = b.x1 - b.x0;
      hb  = b.y1 - b.y0;
      uni = wa * ha + wb * hb - ov;
      return (ov << IOU_SHIFT) <= uni * longint'(thr);
    endfunction

    // judge an accepted box and queue the word it must produce
    function void note_box(cand_t c);
      rect_t       cur;
      verdict_t    v;
      int unsigned k;
      cur = c.box;
      // inverted edges collapse to zero extent
      if (cur.x1 < cur.x0) cur.x1 = cur.x0;
      if (cur.y1 < cur.y0) cur.y1 = cur.y0;
      v.keep = 1'b1;
      v.ovf  = 1'b0;
      for (k = 0; k < kept_n && v.keep; k++) v.keep = iou_ok(cur, kept_list[k]);
      if (v.keep) begin
        if (kept_n < KEPT_DEPTH) begin
          kept_list[kept_n] = cur;
          kept_n++;
        end else begin
          v.ovf = 1'b1;
        end
      end
      if (c.last) kept_n = 0;
      v.idx  = c.idx;
      v.cls  = c.cls;
      v.done = c.last;
      verdict_q = {verdict_q, v};
    endfunction

    task report(string what);
      if (errors < 100) $display("MISMATCH @%0t word %0d: %s", $time, words, what);
      errors++;
    endtask

    task check_word(verdict_t got);
      verdict_t want;
      words++;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected word, box %0d", got.idx));
        return;
      end
      want = verdict_q.pop_front();
      if (got.keep != want.keep)
        report($sformatf("keep %0d want %0d (box %0d)", got.keep, want.keep, want.idx));
      if (got.idx != want.idx)
        report($sformatf("box index %0d want %0d", got.idx, want.idx));
      if (got.cls != want.cls)
        report($sformatf("class %0d want %0d (box %0d)", got.cls, want.cls, want.idx));
      if (got.ovf != want.ovf)
        report($sformatf("overflow %0d want %0d (box %0d)", got.ovf, want.ovf, want.idx));
      if (got.done != want.done)
        report($sformatf("run done %0d want %0d (box %0d)", got.done, want.done, want.idx));
      if (want.keep) n_keep++;
      else n_drop++;
      if (want.ovf) n_ovf++;
      if (want.done) n_runs++;
    endtask

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for greedy_box_suppression. Directed boxes hit the IoU edge cases
// (identical, touching, inverted, zero-area, full frame, run boundaries),
// one long run fills the kept list past its depth, then random clustered runs
// follow under several thresholds. Sender bursts and receiver stalls are
// random; every result word is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import gbs_pkg::*;
  import nms_tb_pkg::*;

  localparam int WATCHDOG_CYC = 6000;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE_CYC   = 8;
  localparam int RAND_ITEMS   = 450;
  localparam int OVF_ITEMS    = KEPT_DEPTH + 2;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [THR_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PORT_W-1:0] x_min = '0;
  logic [PORT_W-1:0] y_min = '0;
  logic [PORT_W-1:0] x_max = '0;
  logic [PORT_W-1:0] y_max = '0;
  logic [ID_W-1:0]   box_index = '0;
  logic [ID_W-1:0]   class_id = '0;
  logic              last_in_run = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              keep;
  logic [ID_W-1:0]   out_box_index;
  logic [ID_W-1:0]   out_class_id;
  logic              store_overflow;
  logic              run_done;

  nms_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cyc = 0;
  bit          long_hold_req = 1'b0;

  greedy_box_suppression #(
    .MAX_KEPT   (KEPT_DEPTH),
    .COORD_BITS (PORT_W)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .x_min          (x_min),
    .y_min          (y_min),
    .x_max          (x_max),
    .y_max          (y_max),
    .box_index      (box_index),
    .class_id       (class_id),
    .last_in_run    (last_in_run),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keep           (keep),
    .out_box_index  (out_box_index),
    .out_class_id   (out_class_id),
    .store_overflow (store_overflow),
    .run_done       (run_done)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // accepted input word -> scoreboard
  always @(posedge clk) begin : mon_in
    cand_t c;
    if (!rst && in_valid && in_ready) begin
      c.box.x0 = x_min;
      c.box.y0 = y_min;
      c.box.x1 = x_max;
      c.box.y1 = y_max;
      c.idx    = box_index;
      c.cls    = class_id;
      c.last   = last_in_run;
      sb.note_box(c);
    end
  end

  // accepted result word -> check
  always @(posedge clk) begin : mon_out
    verdict_t got;
    if (!rst && out_valid && out_ready) begin
      got.keep = keep;
      got.idx  = out_box_index;
      got.cls  = out_class_id;
      got.ovf  = store_overflow;
      got.done = run_done;
      sb.check_word(got);
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
    if (quiet_cyc == WATCHDOG_CYC) begin
      $display("Watchdog: %0d cycles without a transfer", WATCHDOG_CYC);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver pacing: segments of steady, random, periodic and sparse ready,
  // plus one long hold-off on request
  initial begin : rx_pace
    int unsigned mode, seg, k;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 120);
      for (k = 0; k < seg && !long_hold_req; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (k % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic bit [PORT_W-1:0] clip16(int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[PORT_W-1:0];
  endfunction

  function automatic cand_t mk_box(int unsigned x0, y0, x1, y1, idx, cls, last);
    cand_t c;
    c.box.x0 = clip16(x0);
    c.box.y0 = clip16(y0);
    c.box.x1 = clip16(x1);
    c.box.y1 = clip16(y1);
    c.idx    = 8'(idx);
    c.cls    = 8'(cls);
    c.last   = (last != 0);
    return c;
  endfunction

  // offer one box; bursts of random length with random gaps between them
  task drive_box(cand_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    x_min       <= c.box.x0;
    y_min       <= c.box.y0;
    x_max       <= c.box.x1;
    y_max       <= c.box.y1;
    box_index   <= c.idx;
    class_id    <= c.cls;
    last_in_run <= c.last;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // stop offering and wait until every outstanding word has come back
  task quiesce(int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task write_threshold(bit [THR_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.thr = v;
    cfg_writes++;
  endtask

  // one run of boxes clustered around an anchor, with some noise boxes
  task random_run();
    int unsigned len, ax, ay, sz, bx, by, i;
    bit [ID_W-1:0] cls;
    cand_t c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    cls = 8'($urandom_range(0, 255));
    ax  = $urandom_range(0, 62000);
    ay  = $urandom_range(0, 62000);
    sz  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(32, 3000);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // full-range edges, often inverted
        c.box.x0 = 16'($urandom_range(0, 65535));
        c.box.y0 = 16'($urandom_range(0, 65535));
        c.box.x1 = 16'($urandom_range(0, 65535));
        c.box.y1 = 16'($urandom_range(0, 65535));
      end else begin
        bx = ax + $urandom_range(0, sz / 4);
        by = ay + $urandom_range(0, sz / 4);
        c.box.x0 = clip16(bx);
        c.box.y0 = clip16(by);
        c.box.x1 = clip16(bx + sz / 2 + $urandom_range(0, sz));
        c.box.y1 = clip16(by + sz / 2 + $urandom_range(0, sz));
      end
      c.idx  = 8'($urandom_range(0, 255));
      c.cls  = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255)) : cls;
      // some runs end without the last flag, so kept boxes carry over
      c.last = (i == len - 1) && ($urandom_range(0, 9) != 0);
      drive_box(c);
    end
  endtask

  initial begin : stimulus
    cand_t       c;
    rect_t       first_box, tail_box;
    int unsigned i, slot, w, y0, next_cfg, k, rand_goal;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset threshold (0.3)
    drive_box(mk_box(0, 0, 160, 160, 0, 0, 0));             // first box kept
    drive_box(mk_box(0, 0, 160, 160, 1, 0, 0));             // identical, dropped
    drive_box(mk_box(80, 0, 240, 160, 2, 0, 0));            // IoU 1/3, dropped
    drive_box(mk_box(100, 0, 260, 160, 3, 0, 0));           // IoU 0.23, kept
    drive_box(mk_box(500, 20, 400, 90, 4, 0, 0));           // inverted x
    drive_box(mk_box(20, 900, 90, 800, 5, 0, 0));           // inverted y
    drive_box(mk_box(40, 40, 40, 40, 6, 0, 0));             // zero area
    drive_box(mk_box(40, 40, 40, 40, 7, 0, 0));             // zero union vs twin
    drive_box(mk_box(65520, 65520, 65535, 65535, 255, 0, 0));
    drive_box(mk_box(0, 0, 65535, 65535, 128, 0, 0));       // full frame
    drive_box(mk_box(0, 0, 160, 160, 255, 255, 1));         // run end, dropped
    drive_box(mk_box(0, 0, 160, 160, 9, 85, 0));            // list was cleared
    drive_box(mk_box(0, 0, 160, 160, 10, 170, 1));          // class change mid-run
    quiesce(SETTLE_CYC);

    // threshold 0: any overlap suppresses, touching does not
    write_threshold(16'h0000);
    drive_box(mk_box(0, 0, 160, 160, 11, 1, 0));
    drive_box(mk_box(160, 0, 320, 160, 12, 1, 0));
    drive_box(mk_box(319, 0, 400, 160, 13, 1, 1));
    quiesce(SETTLE_CYC);

    // threshold max: only near-identical boxes suppress
    write_threshold(16'hFFFF);
    drive_box(mk_box(0, 0, 160, 160, 14, 2, 0));
    drive_box(mk_box(0, 0, 160, 160, 15, 2, 0));
    drive_box(mk_box(0, 0, 160, 159, 16, 2, 0));
    drive_box(mk_box(0, 0, 65535, 65535, 17, 2, 1));
    quiesce(SETTLE_CYC);

    // fill the kept list past its depth with disjoint boxes
    write_threshold(16'h8000);
    for (i = 0; i < OVF_ITEMS; i++) begin
      slot = (i * 101) % OVF_ITEMS;
      w    = (i == 0) ? 8 : $urandom_range(0, 15);
      y0   = $urandom_range(0, 60000);
      c    = mk_box(slot * 16, y0, slot * 16 + w, y0 + $urandom_range(1, 5000), i, 42, 0);
      if (i == 0) first_box = c.box;
      tail_box = c.box;
      drive_box(c);
    end
    // stored box hit again: dropped; unstored overflow box again: kept, overflow
    c.box = first_box; c.idx = 8'd200; c.cls = 8'd42; c.last = 1'b0;
    drive_box(c);
    c.box = tail_box; c.idx = 8'd201; c.last = 1'b1;
    drive_box(c);
    quiesce(SETTLE_CYC);

    // random clustered runs; receiver holds off hard at the start
    write_threshold(16'($urandom_range(0, 65535)));
    long_hold_req = 1'b1;
    rand_goal = sent + RAND_ITEMS;
    next_cfg  = sent + 90;
    k = 0;
    while (sent < rand_goal) begin
      random_run();
      if (sent >= next_cfg) begin
        quiesce(SETTLE_CYC);
        case (k % 5)
          0: write_threshold(16'h0000);
          1: write_threshold(16'hFFFF);
          2: write_threshold(THR_RESET);
          3: write_threshold(16'($urandom_range(1, 65534)));
          default: write_threshold(16'($urandom_range(8000, 40000)));
        endcase
        k++;
        next_cfg = sent + 90;
      end
    end
    quiesce(2 * KEPT_DEPTH + 8);

    $display("Sent %0d boxes, %0d closed runs: %0d kept, %0d suppressed, %0d past a full list",
             sent, sb.n_runs, sb.n_keep, sb.n_drop, sb.n_ovf);
    $display("Threshold written %0d times incl. 0 and max; one %0d-cycle output hold-off",
             cfg_writes, LONG_HOLD);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/gbs_pkg.sv
rtl/gbs_cell.sv
rtl/gbs_ctrl.sv
rtl/greedy_box_suppression.sv
rtl/gbs_checker.sv
bench/nms_tb_pkg.sv
bench/tb_top.sv
